### design/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared result codes and command codes of the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_FIRED    = 3'd1,
    EV_FULL     = 3'd2,
    EV_NULL     = 3'd3,
    EV_IDLE     = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_NOW  = 2'd2
  } cmd_t;

endpackage

### design/dltq_front.sv
// ----------------------------------------------------------------------------
// dltq_front
// Accepts input transactions, classifies them and queues commands for the
// back part. Null-handle and zero-delay adds go into the queue as immediate results.
// ----------------------------------------------------------------------------
module dltq_front
  import dltq_pkg::*;
#(
  parameter int DELAY_BITS  = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [DELAY_BITS-1:0]  delay,
  input  logic [HANDLE_BITS-1:0] handle,
  output logic                   q_valid,
  input  logic                   q_take,
  output cmd_t                   q_cmd,
  output ev_t                    q_ev,
  output logic [DELAY_BITS-1:0]  q_delay,
  output logic [HANDLE_BITS-1:0] q_handle
);

  localparam int DEPTH = 2;

  cmd_t                   cmd_mem [DEPTH];
  ev_t                    ev_mem  [DEPTH];
  logic [DELAY_BITS-1:0]  dly_mem [DEPTH];
  logic [HANDLE_BITS-1:0] hdl_mem [DEPTH];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;
  logic                   pop;
  cmd_t                   cls_cmd;
  ev_t                    cls_ev;

  assign in_stall = (count == 2'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;

  always_comb begin
    cls_cmd = CMD_ADD;
    cls_ev  = EV_ACCEPTED;
    if (action) begin
      cls_cmd = CMD_TICK;
    end else if (handle == '0) begin
      cls_cmd = CMD_NOW;
      cls_ev  = EV_NULL;
    end else if (delay == '0) begin
      cls_cmd = CMD_NOW;
      cls_ev  = EV_FIRED;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr] <= cls_cmd;
      ev_mem[wr_ptr]  <= cls_ev;
      dly_mem[wr_ptr] <= delay;
      hdl_mem[wr_ptr] <= handle;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign q_cmd    = cmd_mem[rd_ptr];
  assign q_ev     = ev_mem[rd_ptr];
  assign q_delay  = dly_mem[rd_ptr];
  assign q_handle = hdl_mem[rd_ptr];

endmodule

### design/dltq_back.sv
// ----------------------------------------------------------------------------
// dltq_back
// Carries out queued commands on the slot pool: free-slot search, sorted
// insertion by list walk, and tick processing with head pops.
// ----------------------------------------------------------------------------
module dltq_back
  import dltq_pkg::*;
#(
  parameter int SLOTS       = 64,
  parameter int DELAY_BITS  = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_take,
  input  cmd_t                   q_cmd,
  input  ev_t                    q_ev,
  input  logic [DELAY_BITS-1:0]  q_delay,
  input  logic [HANDLE_BITS-1:0] q_handle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             event_res,
  output logic [HANDLE_BITS-1:0] fired_handle,
  output logic                   last
);

  localparam int PW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FREE  = 8'b00000010,
    S_WALK  = 8'b00000100,
    S_LINK  = 8'b00001000,
    S_TICK  = 8'b00010000,
    S_POP   = 8'b00100000,
    S_NEXT  = 8'b01000000,
    S_RD    = 8'b10000000
  } state_t;

  state_t                 state;
  logic [DELAY_BITS-1:0]  dly_mem  [SLOTS];
  logic [HANDLE_BITS-1:0] hdl_mem  [SLOTS];
  logic [PW-1:0]          link_mem [SLOTS];
  logic [SLOTS-1:0]       used;
  logic [PW-1:0]          head;
  logic [PW-1:0]          free_slot;
  logic [PW-1:0]          scan;
  logic [PW-1:0]          prev;
  logic [PW-1:0]          cur;
  logic [DELAY_BITS-1:0]  rem;
  logic [HANDLE_BITS-1:0] req_handle;
  logic [HANDLE_BITS-1:0] pend_hdl;
  logic [DELAY_BITS-1:0]  rd_dly;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic [PW-1:0]          rd_link;
  logic                   fired_any;
  logic                   out_free;
  logic                   nil_cur;

  assign out_free = !out_valid || !out_stall;
  assign q_take   = (state == S_IDLE) && q_valid && out_free;
  assign nil_cur  = (cur >= PW'(SLOTS));

  always_ff @(posedge clk) begin
    if (!nil_cur) begin
      rd_dly  <= dly_mem[cur[IW-1:0]];
      rd_hdl  <= hdl_mem[cur[IW-1:0]];
      rd_link <= link_mem[cur[IW-1:0]];
    end
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      head      <= PW'(SLOTS);
      out_valid <= 1'b0;
      cur       <= PW'(SLOTS);
      fired_any <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_take) begin
            req_handle <= q_handle;
            rem        <= q_delay;
            unique case (q_cmd)
              CMD_NOW: begin
                out_valid    <= 1'b1;
                event_res    <= q_ev;
                fired_handle <= (q_ev == EV_NULL) ? '0 : q_handle;
                last         <= 1'b1;
              end
              CMD_TICK: begin
                fired_any <= 1'b0;
                cur       <= head;
                state     <= S_TICK;
              end
              default: begin
                scan  <= '0;
                state <= S_FREE;
              end
            endcase
          end
        end
        S_FREE: begin
          if (scan >= PW'(SLOTS)) begin
            out_valid    <= 1'b1;
            event_res    <= EV_FULL;
            fired_handle <= req_handle;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else if (!used[scan[IW-1:0]]) begin
            free_slot <= scan;
            prev      <= PW'(SLOTS);
            cur       <= head;
            state     <= S_RD;
          end else begin
            scan <= scan + PW'(1);
          end
        end
        S_RD: begin
          state <= nil_cur ? S_LINK : S_WALK;
        end
        S_WALK: begin
          if (rd_dly >= rem) begin
            state <= S_LINK;
          end else begin
            rem   <= rem - rd_dly;
            prev  <= cur;
            cur   <= rd_link;
            state <= S_RD;
          end
        end
        S_LINK: begin
          hdl_mem[free_slot[IW-1:0]]  <= req_handle;
          dly_mem[free_slot[IW-1:0]]  <= rem;
          link_mem[free_slot[IW-1:0]] <= cur;
          used[free_slot[IW-1:0]]     <= 1'b1;
          if (!nil_cur) dly_mem[cur[IW-1:0]] <= rd_dly - rem;
          if (prev < PW'(SLOTS)) link_mem[prev[IW-1:0]] <= free_slot;
          else head <= free_slot;
          out_valid    <= 1'b1;
          event_res    <= EV_ACCEPTED;
          fired_handle <= req_handle;
          last         <= 1'b1;
          state        <= S_IDLE;
        end
        S_TICK: begin
          if (nil_cur) begin
            out_valid    <= 1'b1;
            event_res    <= EV_IDLE;
            fired_handle <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (!fired_any && rd_dly > DELAY_BITS'(1)) begin
            dly_mem[cur[IW-1:0]] <= rd_dly - DELAY_BITS'(1);
            out_valid    <= 1'b1;
            event_res    <= EV_IDLE;
            fired_handle <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else if (fired_any && !out_free) begin
            state <= S_POP;
          end else if (fired_any && rd_dly != '0) begin
            out_valid    <= 1'b1;
            event_res    <= EV_FIRED;
            fired_handle <= pend_hdl;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            if (fired_any) begin
              out_valid    <= 1'b1;
              event_res    <= EV_FIRED;
              fired_handle <= pend_hdl;
              last         <= 1'b0;
            end
            pend_hdl             <= rd_hdl;
            used[cur[IW-1:0]]    <= 1'b0;
            dly_mem[cur[IW-1:0]] <= '0;
            hdl_mem[cur[IW-1:0]] <= '0;
            head      <= rd_link;
            cur       <= rd_link;
            fired_any <= 1'b1;
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (nil_cur) begin
            if (out_free) begin
              out_valid    <= 1'b1;
              event_res    <= EV_FIRED;
              fired_handle <= pend_hdl;
              last         <= 1'b1;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_POP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/delta_list_timer_queue_top.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top
// Timer queue held as a delta list over a fixed pool of slots.
// ----------------------------------------------------------------------------
// An add searches the slots for a free one, then walks the list through the single
// read port of the slot memories, reading each entry before it is compared; a tick
// pops fired entries from the head one by one and waits while the output is stalled.
// A two-entry queue parts the input side from the slot engine, so transactions
// are taken while one is worked on.
module delta_list_timer_queue_top
  import dltq_pkg::*;
#(
  parameter int SLOTS       = 64,
  parameter int DELAY_BITS  = 16,
  parameter int HANDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [DELAY_BITS-1:0]  delay,
  input  logic [HANDLE_BITS-1:0] handle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             event_res,
  output logic [HANDLE_BITS-1:0] fired_handle,
  output logic                   last
);

  logic                   q_valid;
  logic                   q_take;
  cmd_t                   q_cmd;
  ev_t                    q_ev;
  logic [DELAY_BITS-1:0]  q_delay;
  logic [HANDLE_BITS-1:0] q_handle;

  dltq_front #(.DELAY_BITS(DELAY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .action, .delay, .handle,
    .q_valid, .q_take, .q_cmd, .q_ev, .q_delay, .q_handle
  );

  dltq_back #(.SLOTS(SLOTS), .DELAY_BITS(DELAY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_cmd, .q_ev, .q_delay, .q_handle,
    .out_valid, .out_stall, .event_res, .fired_handle, .last
  );

endmodule

### tb/sv/delta_list_timer_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top_tb
// Self-checking bench for the delta list timer queue.
// ----------------------------------------------------------------------------
// Add and tick transactions go in through a randomly idling driver. A local
// delta list mirrors the slot pool and predicts every result. A monitor with
// random stalls compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top_tb;
  import dltq_pkg::*;

  localparam int NSLOT = 64;

  typedef struct packed {
    logic        action;
    logic [15:0] delay;
    logic [7:0]  handle;
  } timer_req_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] hnd;
    logic       lst;
  } timer_ev_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [15:0] delay = '0;
  logic [7:0] handle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] event_res;
  logic [7:0] fired_handle;
  logic last;

  timer_req_t pending_reqs[$];
  timer_ev_t  expected_events[$];
  int         error_count = 0;
  int         gap_left = 0;
  int         stall_left = 0;

  logic [15:0] mirror_delay[NSLOT];
  logic [7:0]  mirror_handle[NSLOT];
  int          mirror_link[NSLOT];
  int          mirror_head;

  delta_list_timer_queue_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .delay(delay), .handle(handle), .out_valid(out_valid),
    .out_stall(out_stall), .event_res(event_res), .fired_handle(fired_handle),
    .last(last)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_event(ev_t ev, logic [7:0] h, logic l);
    timer_ev_t e;
    e.ev = ev;
    e.hnd = h;
    e.lst = l;
    expected_events.push_back(e);
  endtask

  task automatic predict_timer(timer_req_t r);
    int free_idx;
    int prev;
    int cur;
    int n;
    logic [15:0] rem;
    free_idx = NSLOT;
    prev = NSLOT;
    cur = mirror_head;
    rem = r.delay;
    n = 0;
    if (r.action == 1'b0) begin
      if (r.handle == 0) begin
        queue_event(EV_NULL, 8'd0, 1'b1);
      end else if (r.delay == 0) begin
        queue_event(EV_FIRED, r.handle, 1'b1);
      end else begin
        for (int i = 0; i < NSLOT; i++) begin
          if (mirror_handle[i] == 0 && free_idx == NSLOT) free_idx = i;
        end
        if (free_idx == NSLOT) begin
          queue_event(EV_FULL, r.handle, 1'b1);
        end else begin
          while (cur < NSLOT && mirror_delay[cur] < rem) begin
            rem -= mirror_delay[cur];
            prev = cur;
            cur = mirror_link[cur];
          end
          mirror_handle[free_idx] = r.handle;
          mirror_delay[free_idx] = rem;
          mirror_link[free_idx] = cur;
          if (cur < NSLOT) mirror_delay[cur] -= rem;
          if (prev < NSLOT) mirror_link[prev] = free_idx;
          else mirror_head = free_idx;
          queue_event(EV_ACCEPTED, r.handle, 1'b1);
        end
      end
    end else begin
      if (mirror_head < NSLOT) begin
        if (mirror_delay[mirror_head] != 0) mirror_delay[mirror_head] -= 1;
        while (mirror_head < NSLOT && mirror_delay[mirror_head] == 0) begin
          cur = mirror_head;
          if (n > 0) expected_events[$].lst = 1'b0;
          queue_event(EV_FIRED, mirror_handle[cur], 1'b1);
          n++;
          mirror_head = mirror_link[cur];
          mirror_handle[cur] = 0;
        end
      end
      if (n == 0) queue_event(EV_IDLE, 8'd0, 1'b1);
    end
  endtask

  task automatic add_req(logic a, logic [15:0] d, logic [7:0] h);
    timer_req_t r;
    r.action = a;
    r.delay = d;
    r.handle = h;
    pending_reqs.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_timer(timer_req_t'{action, delay, handle});
        gap_left = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          {action, delay, handle} <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    timer_ev_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result ev=%0d handle=%0d last=%0b", $time,
                   event_res, fired_handle, last);
          error_count++;
        end else begin
          e = expected_events.pop_front();
          if (event_res !== e.ev) begin
            $display("%0t: event_res expected %0d actual %0d", $time, e.ev, event_res);
            error_count++;
          end
          if (fired_handle !== e.hnd) begin
            $display("%0t: fired_handle expected %0d actual %0d", $time, e.hnd,
                     fired_handle);
            error_count++;
          end
          if (last !== e.lst) begin
            $display("%0t: last expected %0b actual %0b", $time, e.lst, last);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      mirror_delay[i] = '0;
      mirror_handle[i] = '0;
      mirror_link[i] = 0;
    end
    mirror_head = NSLOT;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_req(1'b1, 16'd0, 8'd0);
    add_req(1'b0, 16'd5, 8'd0);
    add_req(1'b0, 16'd0, 8'hFF);
    add_req(1'b0, 16'hFFFF, 8'hAA);
    add_req(1'b0, 16'd1, 8'h55);
    add_req(1'b0, 16'd3, 8'h01);
    add_req(1'b0, 16'd3, 8'h02);
    add_req(1'b0, 16'd2, 8'h03);
    add_req(1'b0, 16'd1, 8'h04);
    for (int i = 0; i < 4; i++) add_req(1'b1, 16'hFFFF, 8'hFF);
    while (pending_reqs.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);

    for (int i = 0; i < 70; i++) add_req(1'b0, 16'($urandom_range(1, 4)), 8'(i + 1));
    for (int i = 0; i < 6; i++) add_req(1'b1, 16'($urandom), 8'($urandom));

    for (int i = 0; i < 350; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) add_req(1'b1, 16'($urandom), 8'($urandom));
      else if (r < 45) add_req(1'b0, 16'($urandom), 8'd0);
      else if (r < 50) add_req(1'b0, 16'd0, 8'($urandom));
      else if (r < 55) add_req(1'b0, 16'($urandom), 8'($urandom_range(1, 255)));
      else add_req(1'b0, 16'($urandom_range(1, 12)), 8'($urandom_range(1, 255)));
    end
    for (int i = 0; i < 40; i++) add_req(1'b1, 16'd0, 8'd0);

    while (pending_reqs.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
design/dltq_pkg.sv
design/dltq_front.sv
design/dltq_back.sv
design/delta_list_timer_queue_top.sv
tb/sv/delta_list_timer_queue_top_tb.sv
